FILE: rtl/sce_pkg.sv
// ============================================================================
// sce_pkg: shared types, constants and microcode for the servo easing block
// Holds the fixed-point formats, payload structs, the control/status structs
// between sequencer and datapath, and the microprogram table.
// ============================================================================
package sce_pkg;

    // Fixed-point formats.
    localparam int TIME_WIDTH      = 32;
    localparam int ANGLE_FRAC_BITS = 8;
    localparam int EASE_FRAC_BITS  = 16;
    localparam int ANGLE_WIDTH     = 16;
    localparam int DUR_MS_WIDTH    = 23;
    localparam int PULSE_WIDTH     = 11;
    localparam int EASE_WIDTH      = EASE_FRAC_BITS + 1;

    localparam logic [ANGLE_WIDTH-1:0] ANGLE_MAX = ANGLE_WIDTH'(180 << ANGLE_FRAC_BITS);
    localparam logic [EASE_WIDTH-1:0]  EASE_ONE  = EASE_WIDTH'(1) << EASE_FRAC_BITS;

    // Duration in microseconds is the millisecond count times 1000.
    localparam int                US_PER_MS_WIDTH = 10;
    localparam logic [US_PER_MS_WIDTH-1:0] US_PER_MS = US_PER_MS_WIDTH'(1000);
    localparam int                DUR_PROD_WIDTH  = DUR_MS_WIDTH + US_PER_MS_WIDTH;

    // Pulse width: 1000 + angle*1000/ANGLE_MAX, and ANGLE_MAX = 45 * 2^(frac+2),
    // so the division is a shift followed by a divide by 45. The divide by 45
    // is a multiply by ceil(2^22/45) and a shift by 22, exact for every
    // shifted value up to 45000.
    localparam logic [PULSE_WIDTH-1:0] PULSE_BASE  = PULSE_WIDTH'(1000);
    localparam int                     SCALED_WIDTH = ANGLE_WIDTH + US_PER_MS_WIDTH;
    localparam int                     PULSE_SHIFT  = ANGLE_FRAC_BITS + 2;
    localparam int                     PULSE_RECIP_WIDTH = 17;
    localparam int                     PULSE_RECIP_SHIFT = 22;
    localparam logic [PULSE_RECIP_WIDTH-1:0] PULSE_RECIP = PULSE_RECIP_WIDTH'(93207);

    // Radix-2 divider for the ease fraction: one quotient bit per step.
    localparam int QUO_WIDTH = EASE_FRAC_BITS;
    localparam int CNT_WIDTH = $clog2(QUO_WIDTH);
    localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(QUO_WIDTH - 1);
    localparam int PULSE_PROD_WIDTH = QUO_WIDTH + PULSE_RECIP_WIDTH;

    // Configuration register indexes (word address bit 2).
    localparam logic REG_INITIAL_ANGLE = 1'b0;
    localparam logic REG_MOVE_DURATION = 1'b1;
    localparam int   PADDR_WIDTH       = 3;

    localparam logic [DUR_MS_WIDTH-1:0] DUR_MS_RESET = DUR_MS_WIDTH'(1000);

    typedef struct packed {
        logic                   cmd;
        logic [TIME_WIDTH-1:0]  now_us;
        logic [ANGLE_WIDTH-1:0] target_angle;
    } in_item_t;

    typedef struct packed {
        logic [ANGLE_WIDTH-1:0] angle_now;
        logic [PULSE_WIDTH-1:0] pulse_us;
        logic                   moving;
    } out_item_t;

    // Micro-operations.
    localparam int OP_WIDTH = 4;
    localparam logic [OP_WIDTH-1:0] OP_NOP      = 4'd0;
    localparam logic [OP_WIDTH-1:0] OP_PREP     = 4'd1;
    localparam logic [OP_WIDTH-1:0] OP_DIV_T    = 4'd2;
    localparam logic [OP_WIDTH-1:0] OP_DIV_STEP = 4'd3;
    localparam logic [OP_WIDTH-1:0] OP_SQUARE   = 4'd4;
    localparam logic [OP_WIDTH-1:0] OP_EASE     = 4'd5;
    localparam logic [OP_WIDTH-1:0] OP_BLEND    = 4'd6;
    localparam logic [OP_WIDTH-1:0] OP_SNAP     = 4'd7;
    localparam logic [OP_WIDTH-1:0] OP_MOVE     = 4'd8;
    localparam logic [OP_WIDTH-1:0] OP_SCALE    = 4'd9;
    localparam logic [OP_WIDTH-1:0] OP_DIV_P    = 4'd10;
    localparam logic [OP_WIDTH-1:0] OP_EMIT     = 4'd11;

    // Jump conditions.
    localparam int JC_WIDTH = 3;
    localparam logic [JC_WIDTH-1:0] JC_NEVER      = 3'd0;
    localparam logic [JC_WIDTH-1:0] JC_ALWAYS     = 3'd1;
    localparam logic [JC_WIDTH-1:0] JC_NEW_TARGET = 3'd2;
    localparam logic [JC_WIDTH-1:0] JC_IDLE       = 3'd3;
    localparam logic [JC_WIDTH-1:0] JC_REACHED    = 3'd4;
    localparam logic [JC_WIDTH-1:0] JC_DIV_MORE   = 3'd5;
    localparam logic [JC_WIDTH-1:0] JC_OUT_FULL   = 3'd6;

    localparam int PC_WIDTH = 4;

    // Program labels.
    localparam logic [PC_WIDTH-1:0] L_START   = 4'd0;
    localparam logic [PC_WIDTH-1:0] L_DIV_T   = 4'd4;
    localparam logic [PC_WIDTH-1:0] L_SNAP    = 4'd8;
    localparam logic [PC_WIDTH-1:0] L_MOVE    = 4'd9;
    localparam logic [PC_WIDTH-1:0] L_PULSE   = 4'd10;
    localparam logic [PC_WIDTH-1:0] L_EMIT    = 4'd12;

    typedef struct packed {
        logic [OP_WIDTH-1:0] op;
        logic [JC_WIDTH-1:0] cond;
        logic [PC_WIDTH-1:0] target;
        logic                last;
    } uword_t;

    typedef struct packed {
        logic [OP_WIDTH-1:0] op;
    } ctrl_t;

    typedef struct packed {
        logic new_target;
        logic idle;
        logic reached;
        logic div_last;
        logic out_full;
    } stat_t;

    function automatic uword_t ucode_rom(input logic [PC_WIDTH-1:0] pc);
        uword_t w;
        begin
            w = '{op: OP_NOP, cond: JC_NEVER, target: L_START, last: 1'b0};
            case (pc)
                4'd0:    w = '{op: OP_PREP,     cond: JC_NEW_TARGET, target: L_MOVE,  last: 1'b0};
                4'd1:    w = '{op: OP_NOP,      cond: JC_IDLE,       target: L_PULSE, last: 1'b0};
                4'd2:    w = '{op: OP_NOP,      cond: JC_REACHED,    target: L_SNAP,  last: 1'b0};
                4'd3:    w = '{op: OP_DIV_T,    cond: JC_NEVER,      target: L_START, last: 1'b0};
                4'd4:    w = '{op: OP_DIV_STEP, cond: JC_DIV_MORE,   target: L_DIV_T, last: 1'b0};
                4'd5:    w = '{op: OP_SQUARE,   cond: JC_NEVER,      target: L_START, last: 1'b0};
                4'd6:    w = '{op: OP_EASE,     cond: JC_NEVER,      target: L_START, last: 1'b0};
                4'd7:    w = '{op: OP_BLEND,    cond: JC_ALWAYS,     target: L_PULSE, last: 1'b0};
                4'd8:    w = '{op: OP_SNAP,     cond: JC_ALWAYS,     target: L_PULSE, last: 1'b0};
                4'd9:    w = '{op: OP_MOVE,     cond: JC_NEVER,      target: L_START, last: 1'b0};
                4'd10:   w = '{op: OP_SCALE,    cond: JC_NEVER,      target: L_START, last: 1'b0};
                4'd11:   w = '{op: OP_DIV_P,    cond: JC_NEVER,      target: L_START, last: 1'b0};
                4'd12:   w = '{op: OP_EMIT,     cond: JC_OUT_FULL,   target: L_EMIT,  last: 1'b1};
                default: w = '{op: OP_NOP,      cond: JC_NEVER,      target: L_START, last: 1'b1};
            endcase
            return w;
        end
    endfunction

    // Angles above 180 degrees are held at 180 degrees.
    function automatic logic [ANGLE_WIDTH-1:0] clamp_angle(input logic [ANGLE_WIDTH-1:0] a);
        begin
            return (a > ANGLE_MAX) ? ANGLE_MAX : a;
        end
    endfunction

endpackage

FILE: rtl/sce_useq.sv
// ============================================================================
// sce_useq: microprogram sequencer
// Steps through the control table, evaluates jump conditions against the
// datapath status and tells the top level when a new item may be taken.
// ============================================================================
module sce_useq
    import sce_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  stat_t stat,
    output ctrl_t ctrl,
    output logic  busy
);

    logic                busy_reg;
    logic                busy_next;
    logic [PC_WIDTH-1:0] pc_reg;
    logic [PC_WIDTH-1:0] pc_next;
    uword_t              word;
    logic                taken;

    assign word = ucode_rom(pc_reg);

    always_comb
    begin
        case (word.cond)
            JC_NEVER:      taken = 1'b0;
            JC_ALWAYS:     taken = 1'b1;
            JC_NEW_TARGET: taken = stat.new_target;
            JC_IDLE:       taken = stat.idle;
            JC_REACHED:    taken = stat.reached;
            JC_DIV_MORE:   taken = !stat.div_last;
            JC_OUT_FULL:   taken = stat.out_full;
            default:       taken = 1'b0;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                pc_next   = L_START;
            end
        end
        else if (taken)
        begin
            pc_next = word.target;
        end
        else if (word.last)
        begin
            busy_next = 1'b0;
        end
        else
        begin
            pc_next = pc_reg + PC_WIDTH'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= L_START;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

    assign ctrl.op = busy_reg ? word.op : OP_NOP;
    assign busy    = busy_reg;

endmodule

FILE: rtl/sce_datapath.sv
// ============================================================================
// sce_datapath: motion state, ease divider, ease, blend and pulse arithmetic
// Executes one micro-operation per cycle and holds the result register.
// ============================================================================
module sce_datapath
    import sce_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    take,
    input  in_item_t                item,
    input  logic                    load_init,
    input  logic [ANGLE_WIDTH-1:0]  init_angle,
    input  logic [DUR_MS_WIDTH-1:0] dur_ms,
    input  ctrl_t                   ctrl,
    output stat_t                   stat,
    output logic                    result_valid,
    input  logic                    result_ready,
    output out_item_t               result
);

    // Motion state.
    logic [ANGLE_WIDTH-1:0] start_reg, start_next;
    logic [ANGLE_WIDTH-1:0] goal_reg, goal_next;
    logic [ANGLE_WIDTH-1:0] present_reg, present_next;
    logic [TIME_WIDTH-1:0]  mstart_reg, mstart_next;
    logic                   motion_reg, motion_next;
    logic                   out_valid_reg, out_valid_next;

    // Item and working registers.
    logic                   cmd_reg;
    logic [TIME_WIDTH-1:0]  now_reg;
    logic [ANGLE_WIDTH-1:0] tgt_reg;
    logic [TIME_WIDTH-1:0]  dur_reg, dur_next;
    logic [TIME_WIDTH-1:0]  elapsed_reg, elapsed_next;
    logic [TIME_WIDTH-1:0]  rem_reg, rem_next;
    logic [QUO_WIDTH-1:0]   quo_reg, quo_next;
    logic [TIME_WIDTH-1:0]  den_reg, den_next;
    logic [CNT_WIDTH-1:0]   cnt_reg, cnt_next;
    logic [EASE_FRAC_BITS-1:0] v_reg, v_next;
    logic                   lo_reg, lo_next;
    logic [2*EASE_FRAC_BITS-1:0] sq_reg, sq_next;
    logic [EASE_WIDTH-1:0]  ease_reg, ease_next;
    logic [SCALED_WIDTH-1:0] scaled_reg, scaled_next;
    out_item_t              out_item_reg, out_item_next;

    // Combinational helpers.
    logic [DUR_PROD_WIDTH-1:0]   dur_prod;
    logic [TIME_WIDTH:0]         div_sh;
    logic [TIME_WIDTH:0]         div_diff;
    logic                        div_ge;
    logic [EASE_WIDTH-1:0]       v_wide;
    logic [2*EASE_FRAC_BITS-1:0] cube;
    logic [EASE_FRAC_BITS-1:0]   cube_q;
    logic                        up;
    logic [ANGLE_WIDTH-1:0]      diff;
    logic [ANGLE_WIDTH+EASE_WIDTH-1:0] blend;
    logic [ANGLE_WIDTH-1:0]      blend_step;
    logic [PULSE_PROD_WIDTH-1:0] pulse_prod;
    logic                        out_full;

    assign dur_prod = DUR_PROD_WIDTH'(dur_ms) * DUR_PROD_WIDTH'(US_PER_MS);

    assign div_sh   = {rem_reg, quo_reg[QUO_WIDTH-1]};
    assign div_diff = div_sh - {1'b0, den_reg};
    assign div_ge   = (div_sh >= {1'b0, den_reg});

    assign v_wide = EASE_ONE - {1'b0, quo_reg};
    assign cube   = sq_reg[2*EASE_FRAC_BITS-1:EASE_FRAC_BITS] * v_reg;
    // 4*s*v >> E is s*v >> (E-2).
    assign cube_q = cube[2*EASE_FRAC_BITS-3:EASE_FRAC_BITS-2];

    assign up         = (goal_reg >= start_reg);
    assign diff       = up ? (goal_reg - start_reg) : (start_reg - goal_reg);
    assign blend      = diff * ease_reg;
    assign blend_step = blend[ANGLE_WIDTH+EASE_FRAC_BITS-1:EASE_FRAC_BITS];

    // Divide by 45 through the reciprocal.
    assign pulse_prod = PULSE_PROD_WIDTH'(scaled_reg[SCALED_WIDTH-1:PULSE_SHIFT])
                      * PULSE_PROD_WIDTH'(PULSE_RECIP);

    assign out_full = out_valid_reg && !result_ready;

    always_comb
    begin
        start_next     = start_reg;
        goal_next      = goal_reg;
        present_next   = present_reg;
        mstart_next    = mstart_reg;
        motion_next    = motion_reg;
        dur_next       = dur_reg;
        elapsed_next   = elapsed_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        den_next       = den_reg;
        cnt_next       = cnt_reg;
        v_next         = v_reg;
        lo_next        = lo_reg;
        sq_next        = sq_reg;
        ease_next      = ease_reg;
        scaled_next    = scaled_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_full;

        case (ctrl.op)
            OP_NOP:
            begin
            end
            OP_PREP:
            begin
                dur_next     = (|dur_prod[DUR_PROD_WIDTH-1:TIME_WIDTH]) ? '1
                                                                         : dur_prod[TIME_WIDTH-1:0];
                elapsed_next = now_reg - mstart_reg;
            end
            OP_DIV_T:
            begin
                rem_next = elapsed_reg;
                quo_next = '0;
                den_next = dur_reg;
                cnt_next = '0;
            end
            OP_DIV_STEP:
            begin
                rem_next = div_ge ? div_diff[TIME_WIDTH-1:0] : div_sh[TIME_WIDTH-1:0];
                quo_next = {quo_reg[QUO_WIDTH-2:0], div_ge};
                cnt_next = cnt_reg + CNT_WIDTH'(1);
            end
            OP_SQUARE:
            begin
                lo_next = !quo_reg[QUO_WIDTH-1];
                if (!quo_reg[QUO_WIDTH-1])
                begin
                    v_next  = quo_reg;
                    sq_next = quo_reg * quo_reg;
                end
                else
                begin
                    v_next  = v_wide[EASE_FRAC_BITS-1:0];
                    sq_next = v_wide[EASE_FRAC_BITS-1:0] * v_wide[EASE_FRAC_BITS-1:0];
                end
            end
            OP_EASE:
            begin
                ease_next = lo_reg ? {1'b0, cube_q} : (EASE_ONE - {1'b0, cube_q});
            end
            OP_BLEND:
            begin
                present_next = up ? (start_reg + blend_step) : (start_reg - blend_step);
            end
            OP_SNAP:
            begin
                start_next   = goal_reg;
                present_next = goal_reg;
                motion_next  = 1'b0;
            end
            OP_MOVE:
            begin
                goal_next   = tgt_reg;
                start_next  = present_reg;
                mstart_next = now_reg;
                motion_next = 1'b1;
            end
            OP_SCALE:
            begin
                scaled_next = SCALED_WIDTH'(present_reg) * SCALED_WIDTH'(US_PER_MS);
            end
            OP_DIV_P:
            begin
                quo_next = QUO_WIDTH'(pulse_prod[PULSE_PROD_WIDTH-1:PULSE_RECIP_SHIFT]);
            end
            OP_EMIT:
            begin
                if (!out_full)
                begin
                    out_valid_next          = 1'b1;
                    out_item_next.angle_now = present_reg;
                    out_item_next.pulse_us  = PULSE_BASE + quo_reg[PULSE_WIDTH-1:0];
                    out_item_next.moving    = motion_reg;
                end
            end
            default:
            begin
            end
        endcase

        if (load_init)
        begin
            start_next   = clamp_angle(init_angle);
            goal_next    = clamp_angle(init_angle);
            present_next = clamp_angle(init_angle);
            motion_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg     <= '0;
            goal_reg      <= '0;
            present_reg   <= '0;
            mstart_reg    <= '0;
            motion_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            start_reg     <= start_next;
            goal_reg      <= goal_next;
            present_reg   <= present_next;
            mstart_reg    <= mstart_next;
            motion_reg    <= motion_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= item.cmd;
            now_reg <= item.now_us;
            tgt_reg <= clamp_angle(item.target_angle);
        end
        dur_reg      <= dur_next;
        elapsed_reg  <= elapsed_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        den_reg      <= den_next;
        v_reg        <= v_next;
        lo_reg       <= lo_next;
        sq_reg       <= sq_next;
        ease_reg     <= ease_next;
        scaled_reg   <= scaled_next;
        out_item_reg <= out_item_next;
    end

    assign stat.new_target = cmd_reg && (tgt_reg != goal_reg);
    assign stat.idle       = !motion_reg;
    assign stat.reached    = (elapsed_reg >= dur_reg);
    assign stat.div_last   = (cnt_reg == CNT_LAST);
    assign stat.out_full   = out_full;

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

endmodule

FILE: rtl/servo_cubic_easing_profiler.sv
// ============================================================================
// servo_cubic_easing_profiler: cubic ease-in/ease-out servo motion profile
// Turns time ticks and target commands into an eased angle and pulse width.
//
//   Channel   Handshake                  Payload      Transfer
//   item      item_valid / item_ready    in_item_t    one tick or target command
//   result    result_valid / result_ready out_item_t  one angle and pulse width
//   config    psel/penable/pwrite, pready paddr/pwdata one register write
//
// A tick with no move running, a new target and a tick that ends a move take
// short paths from acceptance to result; a tick during a move takes the long
// one, which is set by the radix-2 divider that works out the ease fraction;
// the pulse width comes from a reciprocal multiply in one step.
// One item is in work at a time; the next one can be taken in the cycle after
// the result is written, while that result waits in the output register.
// Reset clears the motion state to the reset angle and empties the result.
// A stalled result holds the sequencer only at its final step.
// ============================================================================
module servo_cubic_easing_profiler
    import sce_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  in_item_t               item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output out_item_t              result,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_WIDTH-1:0] paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    // Configuration registers. The initial angle is stored as written; the
    // clamped value is what lands in the motion state.
    logic [ANGLE_WIDTH-1:0]  init_angle_reg;
    logic [ANGLE_WIDTH-1:0]  init_angle_next;
    logic [DUR_MS_WIDTH-1:0] dur_ms_reg;
    logic [DUR_MS_WIDTH-1:0] dur_ms_next;

    logic  cfg_write;
    logic  load_init;
    logic  take;
    logic  busy;
    ctrl_t ctrl;
    stat_t stat;

    // APB writes complete in the access phase; the port never waits.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign load_init = cfg_write && (paddr[2] == REG_INITIAL_ANGLE);

    always_comb
    begin
        init_angle_next = init_angle_reg;
        dur_ms_next     = dur_ms_reg;
        if (cfg_write)
        begin
            case (paddr[2])
                REG_INITIAL_ANGLE: init_angle_next = pwdata[ANGLE_WIDTH-1:0];
                REG_MOVE_DURATION: dur_ms_next     = pwdata[DUR_MS_WIDTH-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_angle_reg <= '0;
            dur_ms_reg     <= DUR_MS_RESET;
        end
        else
        begin
            init_angle_reg <= init_angle_next;
            dur_ms_reg     <= dur_ms_next;
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_INITIAL_ANGLE: prdata = {{(32-ANGLE_WIDTH){1'b0}}, init_angle_reg};
            REG_MOVE_DURATION: prdata = {{(32-DUR_MS_WIDTH){1'b0}}, dur_ms_reg};
            default:           prdata = '0;
        endcase
    end

    // An item is taken whenever the sequencer has finished the previous one.
    assign item_ready = !busy;
    assign take       = item_valid && item_ready;

    sce_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (take),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    // The motion state loads the angle being written, in the same cycle as
    // the register itself.
    sce_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .item         (item),
        .load_init    (load_init),
        .init_angle   (init_angle_next),
        .dur_ms       (dur_ms_reg),
        .ctrl         (ctrl),
        .stat         (stat),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

`ifndef SYNTH
    // A taken item keeps the sequencer busy for at least the next cycle.
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> !item_ready)
        else $error("item_ready high right after an item transfer");

    // The reported angle never exceeds 180 degrees.
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.angle_now <= ANGLE_MAX))
        else $error("angle_now above 180 degrees");

    // The pulse width stays inside the servo range.
    a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.pulse_us >= PULSE_BASE)
                         && (result.pulse_us <= PULSE_WIDTH'(2000)))
        else $error("pulse_us outside 1000 to 2000");
`endif

endmodule
